// File: src/sdcp_pkg.sv
// Shared constants, types and codes for the serial drive command parser.
package sdcp_pkg;

  // Default line buffer capacity in bytes, terminator slot included.
  localparam int LINE_CAPACITY_DEF = 64;

  // Payload widths.
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SPEED_W  = 32;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Characters the parser looks for.
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UC_C  = 8'h43;
  localparam logic [BYTE_W-1:0] CH_UC_D  = 8'h44;
  localparam logic [BYTE_W-1:0] CH_UC_M  = 8'h4D;

  // Saturation limits of the 32-bit values.
  localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

  // Where the parser stands within the current line.
  typedef enum logic [3:0] {
    PH_C,
    PH_M,
    PH_D,
    PH_WS1,
    PH_SGN1,
    PH_DIG1,
    PH_WS2,
    PH_SGN2,
    PH_DIG2,
    PH_DONE,
    PH_FAIL
  } phase_t;

  // Magnitude accumulator after one decimal digit.
  typedef struct packed {
    logic               sat;
    logic [SPEED_W-1:0] mag;
  } digit_acc_t;

endpackage

// File: src/sdcp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
interface sdcp_in_if;
  import sdcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sdcp_out_if;
  import sdcp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic                      led_on;

  modport source (output valid, output status, output left_speed, output right_speed,
                  output led_on, input ready);
  modport sink   (input valid, input status, input left_speed, input right_speed,
                  input led_on, output ready);
endinterface

// File: src/sdcp_in_reg.sv
// Input register stage that captures one received byte per beat.
module sdcp_in_reg (
  input  logic      clk,
  input  logic      rst_n,
  sdcp_in_if.sink   up,
  sdcp_in_if.source down
);
  import sdcp_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  // The register takes a new beat whenever it is empty or being drained.
  assign up.ready     = !valid_r || down.ready;
  assign load         = up.valid && up.ready;
  assign valid_nxt    = load ? 1'b1 : (valid_r && !down.ready);
  assign down.valid   = valid_r;
  assign down.rx_byte = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= up.rx_byte;
    end
  end

endmodule

// File: src/sdcp_core.sv
// Line parser state, per-byte update logic and result register.
module sdcp_core #(
  parameter int LINE_CAPACITY = sdcp_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sdcp_in_if.sink    byte_in,
  sdcp_out_if.source res_out
);
  import sdcp_pkg::*;

  localparam int               CNT_W    = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);

  // Appends one decimal digit to a magnitude, holding it once it passes the limit.
  function automatic digit_acc_t add_digit(input logic [SPEED_W-1:0] mag,
                                           input logic [BYTE_W-1:0]  c,
                                           input logic               neg,
                                           input logic               sat);
    logic [SPEED_W+3:0] wide;
    logic [SPEED_W+3:0] prod;
    logic [SPEED_W+3:0] lim;
    digit_acc_t         r;
    wide  = {4'b0000, mag};
    prod  = (wide << 3) + (wide << 1) + {{SPEED_W{1'b0}}, c[3:0]};
    lim   = neg ? {4'b0000, SPEED_MIN} : {4'b0000, SPEED_MAX};
    r.mag = mag;
    r.sat = sat;
    if (!sat) begin
      if (prod > lim) begin
        r.sat = 1'b1;
      end else begin
        r.mag = prod[SPEED_W-1:0];
      end
    end
    return r;
  endfunction

  // Turns a magnitude and sign into the final two's complement value.
  function automatic logic [SPEED_W-1:0] finish_value(input logic [SPEED_W-1:0] mag,
                                                      input logic               neg,
                                                      input logic               sat);
    logic [SPEED_W-1:0] v;
    if (sat) begin
      v = neg ? SPEED_MIN : SPEED_MAX;
    end else begin
      v = neg ? ({SPEED_W{1'b0}} - mag) : mag;
    end
    return v;
  endfunction

  // Line state.
  phase_t             phase_r,  phase_nxt;
  logic [CNT_W-1:0]   cnt_r,    cnt_nxt;
  logic [SPEED_W-1:0] first_r,  first_nxt;
  logic [SPEED_W-1:0] second_r, second_nxt;
  logic               neg_r,    neg_nxt;
  logic               sat_r,    sat_nxt;
  logic               ended_r,  ended_nxt;
  logic               led_r,    led_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [SPEED_W-1:0]  left_r;
  logic [SPEED_W-1:0]  right_r;

  // Per-byte decode.
  logic [BYTE_W-1:0]   c;
  logic                out_free;
  logic                take;
  logic                is_term;
  logic                is_blank;
  logic                is_sign;
  logic                is_digit;
  logic                is_minus;
  digit_acc_t          add1;
  digit_acc_t          add2;
  logic [SPEED_W-1:0]  fin1;
  logic [SPEED_W-1:0]  fin2;
  logic                res_vld;
  logic [STATUS_W-1:0] res_status;
  logic [SPEED_W-1:0]  res_left;
  logic [SPEED_W-1:0]  res_right;

  // A byte is consumed only when the result register can take what it causes.
  assign out_free      = !out_valid_r || res_out.ready;
  assign byte_in.ready = out_free;
  assign take          = byte_in.valid && out_free;
  assign c             = byte_in.rx_byte;

  // Character classes.
  assign is_term  = (c == CH_CR) || (c == CH_LF);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  assign is_minus = (c == CH_MINUS);
  assign is_sign  = (c == CH_PLUS) || is_minus;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  assign add1 = add_digit(first_r, c, neg_r, sat_r);
  assign add2 = add_digit(second_r, c, neg_r, sat_r);
  assign fin1 = finish_value(first_r, neg_r, sat_r);
  assign fin2 = finish_value(second_r, neg_r, sat_r);

  // Next line state and result for the byte at the head of the input register.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    neg_nxt    = neg_r;
    sat_nxt    = sat_r;
    ended_nxt  = ended_r;
    led_nxt    = led_r;
    res_vld    = 1'b0;
    res_status = STATUS_OK;
    res_left   = '0;
    res_right  = '0;

    if (take) begin
      if (is_term || (cnt_r == CNT_LAST)) begin
        // End of line: report and start over.
        if (is_term) begin
          if ((phase_r == PH_DIG2) || (phase_r == PH_DONE)) begin
            led_nxt    = !led_r;
            res_vld    = 1'b1;
            res_status = STATUS_OK;
            res_left   = first_r;
            res_right  = (phase_r == PH_DIG2) ? fin2 : second_r;
          end else if (cnt_r != '0) begin
            res_vld    = 1'b1;
            res_status = STATUS_BAD;
          end
        end else begin
          res_vld    = 1'b1;
          res_status = STATUS_FULL;
        end
        phase_nxt  = PH_C;
        cnt_nxt    = '0;
        first_nxt  = '0;
        second_nxt = '0;
        neg_nxt    = 1'b0;
        sat_nxt    = 1'b0;
        ended_nxt  = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (c == CH_NUL) begin
          ended_nxt = 1'b1;
        end else if (!ended_r) begin
          unique case (phase_r)
            PH_C: begin
              phase_nxt = (c == CH_UC_C) ? PH_M : PH_FAIL;
            end
            PH_M: begin
              phase_nxt = (c == CH_UC_M) ? PH_D : PH_FAIL;
            end
            PH_D: begin
              phase_nxt = (c == CH_UC_D) ? PH_WS1 : PH_FAIL;
            end
            PH_WS1: begin
              if (is_blank) begin
                phase_nxt = PH_WS1;
              end else if (is_sign) begin
                neg_nxt   = is_minus;
                phase_nxt = PH_SGN1;
              end else if (is_digit) begin
                first_nxt = add1.mag;
                sat_nxt   = add1.sat;
                phase_nxt = PH_DIG1;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_SGN1: begin
              if (is_digit) begin
                first_nxt = add1.mag;
                sat_nxt   = add1.sat;
                phase_nxt = PH_DIG1;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_DIG1: begin
              if (is_digit) begin
                first_nxt = add1.mag;
                sat_nxt   = add1.sat;
              end else begin
                // Close the first number; the byte can only be a blank or a sign to go on.
                first_nxt = fin1;
                neg_nxt   = 1'b0;
                sat_nxt   = 1'b0;
                if (is_blank) begin
                  phase_nxt = PH_WS2;
                end else if (is_sign) begin
                  neg_nxt   = is_minus;
                  phase_nxt = PH_SGN2;
                end else begin
                  phase_nxt = PH_FAIL;
                end
              end
            end
            PH_WS2: begin
              if (is_blank) begin
                phase_nxt = PH_WS2;
              end else if (is_sign) begin
                neg_nxt   = is_minus;
                phase_nxt = PH_SGN2;
              end else if (is_digit) begin
                second_nxt = add2.mag;
                sat_nxt    = add2.sat;
                phase_nxt  = PH_DIG2;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_SGN2: begin
              if (is_digit) begin
                second_nxt = add2.mag;
                sat_nxt    = add2.sat;
                phase_nxt  = PH_DIG2;
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            PH_DIG2: begin
              if (is_digit) begin
                second_nxt = add2.mag;
                sat_nxt    = add2.sat;
              end else begin
                second_nxt = fin2;
                neg_nxt    = 1'b0;
                sat_nxt    = 1'b0;
                phase_nxt  = PH_DONE;
              end
            end
            default: begin
              // Done or failed: the rest of the line is ignored.
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  // Result register valid: loaded on a result, cleared when taken.
  assign out_valid_nxt = out_free ? res_vld : out_valid_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_C;
      cnt_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      neg_r       <= 1'b0;
      sat_r       <= 1'b0;
      ended_r     <= 1'b0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      neg_r       <= neg_nxt;
      sat_r       <= sat_nxt;
      ended_r     <= ended_nxt;
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (out_free && res_vld) begin
      status_r <= res_status;
      left_r   <= res_left;
      right_r  <= res_right;
    end
  end

  // The LED level only changes together with loading an accepted result.
  assign res_out.valid       = out_valid_r;
  assign res_out.status      = status_r;
  assign res_out.left_speed  = $signed(left_r);
  assign res_out.right_speed = $signed(right_r);
  assign res_out.led_on      = led_r;

endmodule

// File: src/serial_drive_command_parser.sv
// Path: in_ch, input register, parse pass, result register, out_ch. Throughput: one received
// byte per cycle; set by the single parse pass between the input register and the result
// register, which takes a byte whenever the result slot is free.
// Reset (rst_n low at a clock edge): the line restarts empty, both values clear, LED off,
// and no result is pending; the block needs no clearing pass.
module serial_drive_command_parser #(
  parameter int LINE_CAPACITY = sdcp_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sdcp_in_if.sink    in_ch,
  sdcp_out_if.source out_ch
);
  import sdcp_pkg::*;

  // Byte channel between the input register and the parser.
  sdcp_in_if byte_ch ();

  sdcp_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_ch),
    .down  (byte_ch)
  );

  sdcp_core #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_in (byte_ch),
    .res_out (out_ch)
  );

  // Only the three defined status codes ever leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == STATUS_OK) || (out_ch.status == STATUS_BAD) ||
                     (out_ch.status == STATUS_FULL))
    else $error("result beat carries an undefined status code");

  // Rejected and overflowed lines report zero speeds.
  a_zero_speeds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STATUS_OK)) |->
      (out_ch.left_speed == '0) && (out_ch.right_speed == '0))
    else $error("non-accepted result beat carries nonzero speeds");

  // The LED flips only when an accepted result is presented.
  a_led_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(out_ch.led_on)) |->
      (out_ch.valid && (out_ch.status == STATUS_OK)))
    else $error("LED level changed without an accepted result");

  // The parser holds off new bytes while a result waits on a stalled output.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !byte_ch.ready)
    else $error("parser took a byte while the result register was stalled");

endmodule
